/* rtl/ehbi_pkg.sv */
`default_nettype none
package ehbi_pkg;

	localparam int BYTE_W   = 8;
	localparam int HASH_W   = 28;
	localparam int WORD_W   = 32;
	localparam int NIB_W    = WORD_W - HASH_W;
	localparam int CNT_W    = 32;
	localparam int STEP_W   = $clog2(HASH_W);
	localparam int OUT_DW   = 64;
	localparam int OUT_PAD  = OUT_DW - HASH_W - CNT_W;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef struct packed {
		logic  valid;
		hash_t hash;
	} push_t;

	// Folds one byte into the hash: shift by a nibble, add, xor the top
	// nibble back in at bits 7:4, and keep the low 28 bits.
	function automatic hash_t fold_byte(input hash_t h, input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] t;
		logic [NIB_W-1:0]  g;
		hash_t             r;
		t = {h, {NIB_W{1'b0}}} + {{(WORD_W-BYTE_W){1'b0}}, b};
		g = t[WORD_W-1 -: NIB_W];
		r = t[HASH_W-1:0];
		r[BYTE_W-1 -: NIB_W] = r[BYTE_W-1 -: NIB_W] ^ g;
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/elf_hash_bucket_index.sv */
`default_nettype none
// System V ELF symbol hash with bucket selection. Name bytes arrive one per
// beat on the slave side and are folded at one per cycle while the queue
// has room; a zero byte (not hashed) or a beat with tlast ends the name.
// Each finished hash goes into a two-entry queue, and a divider takes it
// from there, one quotient bit per cycle; its result is presented from a
// done state, with no division when the bucket count is zero. Short names
// are therefore limited by the divider. The master beat carries the hash
// in tdata bits 27:0 and the bucket index in bits 59:28; tuser flags a zero
// bucket count, in which case the index is 0. The bucket count resets to 1
// and is sampled when a hash enters the divider.
module elf_hash_bucket_index (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [ehbi_pkg::CNT_W-1:0]       cfg_wdata,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [ehbi_pkg::BYTE_W-1:0]      s_tdata,   // name_byte
	input  wire                              s_tlast,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [ehbi_pkg::OUT_DW-1:0]      m_tdata,   // hash_value, bucket_index
	output logic                             m_tuser    // zero_buckets
);
	import ehbi_pkg::*;

	count_t bucket_count_q;
	push_t  push;
	logic   q_ready;
	logic   q_valid;
	hash_t  q_hash;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	ehbi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_ready  (q_ready),
		.push     (push)
	);

	ehbi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_ready (q_ready),
		.q_valid (q_valid),
		.q_hash  (q_hash),
		.pop     (pop)
	);

	ehbi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_hash       (q_hash),
		.pop          (pop),
		.bucket_count (bucket_count_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
`default_nettype wire

/* rtl/ehbi_front.sv */
`default_nettype none
module ehbi_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [ehbi_pkg::BYTE_W-1:0]   s_tdata,
	input  wire                           s_tlast,
	input  wire                           q_ready,
	output ehbi_pkg::push_t               push
);
	import ehbi_pkg::*;

	hash_t hash_q;
	hash_t folded;
	logic  beat;
	logic  zero_byte;

	assign s_tready  = q_ready;
	assign beat      = s_tvalid && q_ready;
	assign zero_byte = (s_tdata == '0);
	assign folded    = fold_byte(hash_q, s_tdata);

	always_comb begin
		push.valid = beat && (zero_byte || s_tlast);
		push.hash  = zero_byte ? hash_q : folded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (beat) begin
			if (zero_byte || s_tlast) begin
				hash_q <= '0;
			end else begin
				hash_q <= folded;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ehbi_queue.sv */
`default_nettype none
module ehbi_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ehbi_pkg::push_t       push,
	output logic                  q_ready,
	output logic                  q_valid,
	output ehbi_pkg::hash_t       q_hash,
	input  wire                   pop
);
	import ehbi_pkg::*;

	hash_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_ready = (fill_q != Q_CNT_W'(Q_DEPTH));
	assign q_valid = (fill_q != '0);
	assign q_hash  = entry_q[rd_q];
	assign do_push = push.valid && q_ready;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push.hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ehbi_back.sv */
`default_nettype none
module ehbi_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               q_valid,
	input  ehbi_pkg::hash_t                   q_hash,
	output logic                              pop,
	input  ehbi_pkg::count_t                  bucket_count,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [ehbi_pkg::OUT_DW-1:0]       m_tdata,
	output logic                              m_tuser
);
	import ehbi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_W - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	hash_t             hash_q;
	hash_t             shift_q;
	count_t            div_q;
	count_t            rem_q;
	logic              zero_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	assign pop      = q_valid && ((state_q == ST_IDLE) || ((state_q == ST_DONE) && m_tready));
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = {{OUT_PAD{1'b0}}, rem_q, hash_q};
	assign m_tuser  = zero_q;
	assign trial    = {rem_q, shift_q[HASH_W-1]};
	assign diff     = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (pop) begin
			hash_q  <= q_hash;
			shift_q <= q_hash;
			div_q   <= bucket_count;
			rem_q   <= '0;
			step_q  <= '0;
			zero_q  <= (bucket_count == '0);
		end else if (state_q == ST_DIV) begin
			shift_q <= shift_q << 1;
			step_q  <= step_q + 1'b1;
			if (!diff[CNT_W]) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= (bucket_count == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (pop) begin
						state_q <= (bucket_count == '0) ? ST_DONE : ST_DIV;
					end else if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/ehbi_checker.sv */
`default_nettype none
module ehbi_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [ehbi_pkg::OUT_DW-1:0]       m_tdata,
	input wire                              m_tuser
);
	import ehbi_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Master beat dropped while stalled.");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DW-1 -: OUT_PAD] == '0))
		else $error("Padding bits of tdata are not zero.");

	a_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[HASH_W +: CNT_W] == '0))
		else $error("Zero bucket count gave a nonzero index.");

	a_zero_hash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[HASH_W-1:0] == '0) |-> (m_tdata[HASH_W +: CNT_W] == '0))
		else $error("A zero hash gave a nonzero index.");

endmodule

bind elf_hash_bucket_index ehbi_checker u_ehbi_checker (.*);
`default_nettype wire

/* tb/tb_elf_hash_bucket_index.sv */
`default_nettype none
module tb_elf_hash_bucket_index;
	import ehbi_pkg::*;

	typedef struct packed {
		hash_t  hash;
		count_t index;
		logic   no_buckets;
	} bucket_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;   // name_byte
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_DW-1:0]   m_tdata;   // hash_value, bucket_index
	logic                m_tuser;   // zero_buckets

	bucket_result_t pending_results[$];
	hash_t          running_hash;
	count_t         n_buckets;
	int             send_idle;
	int             recv_idle;
	int             hold_request;
	int             hold_left;
	int             err_count;

	elf_hash_bucket_index dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic hash_t elf_fold(input hash_t h, input logic [BYTE_W-1:0] b);
		logic [31:0] t;
		t = {h, 4'h0} + {24'h0, b};
		t = t ^ ((t >> 24) & 32'h0000_00F0);
		return t[HASH_W-1:0];
	endfunction

	// Updates the running hash for one accepted beat and queues the result of
	// a finished name.
	function automatic void predict_name_byte(input logic [BYTE_W-1:0] b, input logic l);
		bucket_result_t r;
		if (b != 8'h00) begin
			running_hash = elf_fold(running_hash, b);
			if (!l)
				return;
		end
		r.hash = running_hash;
		r.no_buckets = (n_buckets == 0);
		r.index = r.no_buckets ? '0 : {4'h0, running_hash} % n_buckets;
		pending_results.push_back(r);
		running_hash = '0;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= 30)
			$display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		bucket_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[HASH_W-1:0] !== want.hash)
					report_mismatch("hash_value", 64'(m_tdata[HASH_W-1:0]),
						64'(want.hash));
				if (m_tdata[HASH_W +: CNT_W] !== want.index)
					report_mismatch("bucket_index", 64'(m_tdata[HASH_W +: CNT_W]),
						64'(want.index));
				if (m_tuser !== want.no_buckets)
					report_mismatch("zero_buckets", 64'(m_tuser), 64'(want.no_buckets));
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_name_byte(b, l);
		@(negedge clk);
	endtask

	// Mostly well-formed names of random content, ended either by tlast or by
	// a zero byte; the rest is noise with stray zeros and tlast flags.
	task automatic send_names(input int items);
		int sent;
		int kind;
		int len;
		logic l;
		sent = 0;
		while (sent < items) begin
			kind = $urandom_range(99);
			if (kind < 90) begin
				len = (kind < 70) ? $urandom_range(1, 6) : $urandom_range(7, 40);
				l = 1'($urandom_range(1));
				for (int i = 0; i < len; i++)
					send_byte(BYTE_W'($urandom_range(1, 255)), l && (i == len - 1));
				if (!l) begin
					send_byte(8'h00, 1'($urandom_range(1)));
					sent++;
				end
				sent += len;
			end else begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(3) == 0);
				sent += len;
			end
		end
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_bucket_count(input count_t v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		n_buckets = v;
	endtask

	task automatic test_directed();
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		// Seven 0x0F bytes build 0x0FFFFFFF; the next fold carries past bit 31.
		repeat (7) send_byte(8'h0F, 1'b0);
		send_byte(8'hFF, 1'b1);
		// An eighth 0x0F sets the top nibble, which is folded back in.
		repeat (8) send_byte(8'h0F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		settle();
	endtask

	task automatic test_zero_buckets();
		write_bucket_count(32'h0000_0000);
		send_names(150);
		settle();
	endtask

	task automatic test_max_buckets();
		write_bucket_count(32'hFFFF_FFFF);
		send_names(150);
		settle();
	endtask

	task automatic test_small_buckets();
		write_bucket_count($urandom_range(2, 64));
		send_names(350);
		settle();
	endtask

	task automatic test_hash_range_buckets();
		write_bucket_count(32'h0FFF_FFFF);
		send_names(100);
		settle();
		write_bucket_count(32'h1000_0000);
		send_names(100);
		settle();
	endtask

	task automatic test_random_buckets();
		repeat (3) begin
			write_bucket_count($urandom());
			send_names(180);
			settle();
		end
	endtask

	task automatic test_backpressure();
		write_bucket_count($urandom_range(1, 1000));
		hold_request = 300;
		send_names(250);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		running_hash = '0;
		n_buckets = 32'd1;
		hold_request = 0;
		hold_left = 0;
		err_count = 0;
		send_idle = 6;
		recv_idle = 56;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_zero_buckets();
		test_max_buckets();
		send_idle = 56;
		recv_idle = 6;
		test_small_buckets();
		test_hash_range_buckets();
		send_idle = 0;
		recv_idle = 0;
		test_random_buckets();
		test_backpressure();

		repeat (64) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
